>>> rtl/nfeps_pkg.sv
package nfeps_pkg;

    localparam int unsigned AddrWidth   = 32;
    localparam int unsigned WordWidth   = 16;
    localparam int unsigned SizeWidth   = 21;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [AddrWidth-1:0] FLASH_BASE_RST     = 32'hA000_0000;
    localparam logic [AddrWidth-1:0] SOURCE_BASE_RST    = 32'h8810_0000;
    localparam logic [SizeWidth-1:0] IMAGE_BYTES_RST    = 21'd32768;
    localparam logic [AddrWidth-1:0] INDICATOR_ADDR_RST = 32'hB400_0000;

    localparam logic [AddrWidth-1:0] UNLOCK_A = 32'h0000_AAAA;
    localparam logic [AddrWidth-1:0] UNLOCK_B = 32'h0000_5554;

    localparam logic [WordWidth-1:0] CMD_UNLOCK_1  = 16'h00AA;
    localparam logic [WordWidth-1:0] CMD_UNLOCK_2  = 16'h0055;
    localparam logic [WordWidth-1:0] CMD_RESET     = 16'h00F0;
    localparam logic [WordWidth-1:0] CMD_PROGRAM   = 16'h00A0;
    localparam logic [WordWidth-1:0] CMD_ERASE     = 16'h0080;
    localparam logic [WordWidth-1:0] CMD_CHIP_ERASE = 16'h0010;

    localparam logic [WordWidth-1:0] LED_START = 16'd6;
    localparam logic [WordWidth-1:0] LED_ERASE = 16'd5;
    localparam logic [WordWidth-1:0] LED_PASS  = 16'd0;
    localparam logic [WordWidth-1:0] LED_FAIL  = 16'd1;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_FLASH_BASE     = 3'd0,
        CFG_SOURCE_BASE    = 3'd1,
        CFG_IMAGE_BYTES    = 3'd2,
        CFG_INDICATOR_ADDR = 3'd3,
        CFG_SWAP_BYTES     = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACC_FLASH_WRITE  = 2'd0,
        ACC_FLASH_READ   = 2'd1,
        ACC_SOURCE_READ  = 2'd2,
        ACC_INDICATOR_WR = 2'd3
    } access_kind_t;

    typedef enum logic [1:0] {
        JOB_NONE         = 2'd0,
        JOB_SUCCESS      = 2'd1,
        JOB_ERASE_FAILED = 2'd2,
        JOB_PROG_FAILED  = 2'd3
    } job_status_t;

    typedef enum logic {
        CMD_START     = 1'b0,
        CMD_READ_DATA = 1'b1
    } command_t;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'b00001,
        PH_RESET_READ  = 5'b00010,
        PH_ERASE_POLL  = 5'b00100,
        PH_SOURCE_READ = 5'b01000,
        PH_PROG_POLL   = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        RUN_START   = 3'd0,
        RUN_ERASE   = 3'd1,
        RUN_POLL    = 3'd2,
        RUN_SOURCE  = 3'd3,
        RUN_FINISH  = 3'd4,
        RUN_PROGRAM = 3'd5
    } run_kind_t;

    typedef struct packed {
        logic                 command;
        logic [WordWidth-1:0] read_data;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]           access_kind;
        logic [AddrWidth-1:0] bus_address;
        logic [WordWidth-1:0] write_value;
        logic [1:0]           job_status;
        logic                 last_of_run;
    } acc_item_t;

    function automatic logic [3:0] run_last_index(input run_kind_t kind);
        logic [3:0] last;
        unique case (kind)
            RUN_START:   last = 4'd4;
            RUN_ERASE:   last = 4'd7;
            RUN_PROGRAM: last = 4'd4;
            default:     last = 4'd0;
        endcase
        return last;
    endfunction

endpackage

>>> rtl/nor_flash_erase_program_sequencer.sv
// An accepted command transaction loads the run registers, which select each bus
// access of its run; each access is then registered in the output register.
// Throughput: one access per cycle while acc_stall does not hold the output; a
// command stalls the input until the last of its accesses (zero to eight) is emitted.
// Reset clears the job state and the output valid flag, and loads the register defaults.
module nor_flash_erase_program_sequencer
    import nfeps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [AddrWidth-1:0]   cfg_wdata,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  cmd_item_t              cmd_data,
    output logic                   acc_valid,
    input  logic                   acc_stall,
    output acc_item_t              acc_data
);

    logic [AddrWidth-1:0] flash_base_reg;
    logic [AddrWidth-1:0] source_base_reg;
    logic [SizeWidth-1:0] image_bytes_reg;
    logic [AddrWidth-1:0] indicator_addr_reg;
    logic                 swap_bytes_reg;

    phase_t               phase_reg, phase_next;
    logic [SizeWidth-1:0] offset_reg, offset_next;
    logic [1:0]           first_status_reg, first_status_next;
    logic                 awaiting_reg, awaiting_next;

    logic                 run_valid_reg, run_valid_next;
    run_kind_t            run_kind_reg, run_kind_next;
    logic [3:0]           run_idx_reg, run_idx_next;
    logic [WordWidth-1:0] run_data_reg, run_data_next;
    logic [SizeWidth-1:0] run_off_reg, run_off_next;
    job_status_t          run_status_reg, run_status_next;

    logic                 out_valid_reg;
    acc_item_t            out_reg;

    logic                 out_free;
    logic                 emit;
    logic                 run_last;
    logic                 cmd_accept;
    logic                 has_run;
    acc_item_t            res;

    logic [SizeWidth:0]   limit;
    logic [SizeWidth:0]   next_off;
    logic                 b6;
    logic                 b5;
    logic                 poll_done;
    logic                 poll_fail;
    logic [WordWidth-1:0] word;

    assign out_free   = !out_valid_reg || !acc_stall;
    assign emit       = run_valid_reg && out_free;
    assign run_last   = (run_idx_reg == run_last_index(run_kind_reg));
    assign cmd_stall  = run_valid_reg && !(emit && run_last);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign acc_valid  = out_valid_reg;
    assign acc_data   = out_reg;

    assign limit    = ({1'b0, image_bytes_reg} + {{SizeWidth{1'b0}}, 1'b1})
                      & ~{{SizeWidth{1'b0}}, 1'b1};
    assign next_off = {1'b0, offset_reg} + (SizeWidth+1)'(2);
    assign b6       = cmd_data.read_data[6];
    assign b5       = cmd_data.read_data[5];
    assign poll_done = awaiting_reg && (first_status_reg[1] == b6);
    assign poll_fail = awaiting_reg && !poll_done && first_status_reg[0];
    assign word = swap_bytes_reg ? {cmd_data.read_data[7:0], cmd_data.read_data[15:8]}
                                 : cmd_data.read_data;

    // Next job state and the access run that the command causes.
    always_comb
    begin
        phase_next        = phase_reg;
        offset_next       = offset_reg;
        first_status_next = first_status_reg;
        awaiting_next     = awaiting_reg;
        has_run           = 1'b1;
        run_kind_next     = RUN_POLL;
        run_data_next     = word;
        run_off_next      = offset_reg;
        run_status_next   = JOB_NONE;
        if (cmd_data.command == CMD_START)
        begin
            offset_next       = '0;
            first_status_next = '0;
            awaiting_next     = 1'b0;
            run_kind_next     = RUN_START;
            phase_next        = PH_RESET_READ;
        end
        else
        begin
            unique case (phase_reg)
                PH_RESET_READ:
                begin
                    run_kind_next = RUN_ERASE;
                    phase_next    = PH_ERASE_POLL;
                    awaiting_next = 1'b0;
                end
                PH_SOURCE_READ:
                begin
                    run_kind_next = RUN_PROGRAM;
                    phase_next    = PH_PROG_POLL;
                    awaiting_next = 1'b0;
                end
                PH_ERASE_POLL, PH_PROG_POLL:
                begin
                    if (!awaiting_reg)
                    begin
                        first_status_next = {b6, b5};
                        awaiting_next     = 1'b1;
                    end
                    else
                    begin
                        awaiting_next = 1'b0;
                    end
                    if (poll_fail)
                    begin
                        run_kind_next   = RUN_FINISH;
                        run_status_next = (phase_reg == PH_ERASE_POLL) ? JOB_ERASE_FAILED
                                                                       : JOB_PROG_FAILED;
                        phase_next      = PH_IDLE;
                    end
                    else if (poll_done)
                    begin
                        if (phase_reg == PH_ERASE_POLL)
                        begin
                            offset_next = '0;
                            if (limit != '0)
                            begin
                                run_kind_next = RUN_SOURCE;
                                run_off_next  = '0;
                                phase_next    = PH_SOURCE_READ;
                            end
                            else
                            begin
                                run_kind_next   = RUN_FINISH;
                                run_status_next = JOB_SUCCESS;
                                phase_next      = PH_IDLE;
                            end
                        end
                        else if (next_off < limit)
                        begin
                            offset_next   = next_off[SizeWidth-1:0];
                            run_kind_next = RUN_SOURCE;
                            run_off_next  = next_off[SizeWidth-1:0];
                            phase_next    = PH_SOURCE_READ;
                        end
                        else
                        begin
                            run_kind_next   = RUN_FINISH;
                            run_status_next = JOB_SUCCESS;
                            phase_next      = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    has_run = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        if (emit)
        begin
            if (run_last)
            begin
                run_valid_next = 1'b0;
            end
            else
            begin
                run_idx_next = run_idx_reg + 4'd1;
            end
        end
        if (cmd_accept && has_run)
        begin
            run_valid_next = 1'b1;
            run_idx_next   = '0;
        end
    end

    // One bus access of the current run, selected by its position.
    always_comb
    begin
        res             = '0;
        res.access_kind = ACC_FLASH_WRITE;
        res.last_of_run = run_last;
        unique case (run_kind_reg)
            RUN_START:
            begin
                case (run_idx_reg)
                    4'd0:
                    begin
                        res.access_kind = ACC_INDICATOR_WR;
                        res.bus_address = indicator_addr_reg;
                        res.write_value = LED_START;
                    end
                    4'd1:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_A;
                        res.write_value = CMD_UNLOCK_1;
                    end
                    4'd2:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_B;
                        res.write_value = CMD_UNLOCK_2;
                    end
                    4'd3:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_A;
                        res.write_value = CMD_RESET;
                    end
                    default:
                    begin
                        res.access_kind = ACC_FLASH_READ;
                        res.bus_address = flash_base_reg;
                    end
                endcase
            end
            RUN_ERASE:
            begin
                case (run_idx_reg)
                    4'd0:
                    begin
                        res.access_kind = ACC_INDICATOR_WR;
                        res.bus_address = indicator_addr_reg;
                        res.write_value = LED_ERASE;
                    end
                    4'd1, 4'd4:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_A;
                        res.write_value = CMD_UNLOCK_1;
                    end
                    4'd2, 4'd5:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_B;
                        res.write_value = CMD_UNLOCK_2;
                    end
                    4'd3:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_A;
                        res.write_value = CMD_ERASE;
                    end
                    4'd6:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_A;
                        res.write_value = CMD_CHIP_ERASE;
                    end
                    default:
                    begin
                        res.access_kind = ACC_FLASH_READ;
                        res.bus_address = flash_base_reg;
                    end
                endcase
            end
            RUN_PROGRAM:
            begin
                case (run_idx_reg)
                    4'd0:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_A;
                        res.write_value = CMD_UNLOCK_1;
                    end
                    4'd1:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_B;
                        res.write_value = CMD_UNLOCK_2;
                    end
                    4'd2:
                    begin
                        res.bus_address = flash_base_reg + UNLOCK_A;
                        res.write_value = CMD_PROGRAM;
                    end
                    4'd3:
                    begin
                        res.bus_address = flash_base_reg
                                          + {{(AddrWidth-SizeWidth){1'b0}}, run_off_reg};
                        res.write_value = run_data_reg;
                    end
                    default:
                    begin
                        res.access_kind = ACC_FLASH_READ;
                        res.bus_address = flash_base_reg;
                    end
                endcase
            end
            RUN_SOURCE:
            begin
                res.access_kind = ACC_SOURCE_READ;
                res.bus_address = source_base_reg
                                  + {{(AddrWidth-SizeWidth){1'b0}}, run_off_reg};
            end
            RUN_FINISH:
            begin
                res.access_kind = ACC_INDICATOR_WR;
                res.bus_address = indicator_addr_reg;
                res.write_value = (run_status_reg == JOB_SUCCESS) ? LED_PASS : LED_FAIL;
                res.job_status  = run_status_reg;
            end
            default:
            begin
                res.access_kind = ACC_FLASH_READ;
                res.bus_address = flash_base_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_base_reg     <= FLASH_BASE_RST;
            source_base_reg    <= SOURCE_BASE_RST;
            image_bytes_reg    <= IMAGE_BYTES_RST;
            indicator_addr_reg <= INDICATOR_ADDR_RST;
            swap_bytes_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FLASH_BASE:     flash_base_reg     <= cfg_wdata;
                CFG_SOURCE_BASE:    source_base_reg    <= cfg_wdata;
                CFG_IMAGE_BYTES:    image_bytes_reg    <= cfg_wdata[SizeWidth-1:0];
                CFG_INDICATOR_ADDR: indicator_addr_reg <= cfg_wdata;
                CFG_SWAP_BYTES:     swap_bytes_reg     <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            offset_reg       <= '0;
            first_status_reg <= '0;
            awaiting_reg     <= 1'b0;
            run_valid_reg    <= 1'b0;
            run_idx_reg      <= '0;
            run_kind_reg     <= RUN_POLL;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd_accept)
            begin
                phase_reg        <= phase_next;
                offset_reg       <= offset_next;
                first_status_reg <= first_status_next;
                awaiting_reg     <= awaiting_next;
                if (has_run)
                begin
                    run_kind_reg <= run_kind_next;
                end
            end
            run_valid_reg <= run_valid_next;
            run_idx_reg   <= run_idx_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept && has_run)
        begin
            run_data_reg   <= run_data_next;
            run_off_reg    <= run_off_next;
            run_status_reg <= run_status_next;
        end
        if (emit)
        begin
            out_reg <= res;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> run_idx_reg <= run_last_index(run_kind_reg))
        else $error("Access run position beyond the end of its run.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept && has_run |=> run_valid_reg && run_idx_reg == 4'd0)
        else $error("Accepted command did not start a new access run.");

    assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid && acc_data.job_status != JOB_NONE
        |-> acc_data.access_kind == ACC_INDICATOR_WR && acc_data.last_of_run)
        else $error("Job status reported on an access other than the final indicator write.");

    assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> phase_reg == PH_ERASE_POLL || phase_reg == PH_PROG_POLL)
        else $error("Second status read pending outside a polling phase.");
`endif

endmodule
